>>> rtl/light_gated_motion_lamp_controller_macros.svh
// ----------------------------------------------------------------------------
// lamp controller assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LIGHT_GATED_MOTION_LAMP_CONTROLLER_MACROS_SVH
`define LIGHT_GATED_MOTION_LAMP_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on i_clk, off during reset
`define LGML_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lgml assertion failed");
// next-cycle implication, checked on i_clk, off during reset
`define LGML_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lgml assertion failed");
`else
`define LGML_ASSERT_NOW(label, ante, cons)
`define LGML_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/lgml_pkg.sv
// ----------------------------------------------------------------------------
// lgml_pkg
// shared types and constants of the light gated motion lamp controller
// ----------------------------------------------------------------------------
package lgml_pkg;

    localparam int TPS_W    = 10;
    localparam int SECS_W   = 16;
    localparam int LIGHT_W  = 16;
    localparam int BAT_W    = 16;
    localparam int HOLD_W   = 3;
    localparam int BLANK_W  = 5;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 3;

    // register indexes (byte address is 4 times the index)
    localparam logic [REG_IDX_W-1:0] REG_TPS     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ON_SECS = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BAT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HOLDOFF = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BLANK   = 3'd6;

    localparam logic [TPS_W-1:0]   RST_TPS     = 10'd100;
    localparam logic [SECS_W-1:0]  RST_ON_SECS = 16'd60;
    localparam logic [LIGHT_W-1:0] RST_LOW     = 16'd100;
    localparam logic [LIGHT_W-1:0] RST_HIGH    = 16'd200;
    localparam logic [BAT_W-1:0]   RST_MIN_BAT = 16'd0;
    localparam logic [HOLD_W-1:0]  RST_HOLDOFF = 3'd5;
    localparam logic [BLANK_W-1:0] RST_BLANK   = 5'd20;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_MOTION = 1'b1;

    typedef struct packed {
        logic [TPS_W-1:0]   ticks_per_second;
        logic [SECS_W-1:0]  lamp_on_seconds;
        logic [LIGHT_W-1:0] light_low;
        logic [LIGHT_W-1:0] light_high;
        logic [BAT_W-1:0]   min_battery;
        logic [HOLD_W-1:0]  light_holdoff_seconds;
        logic [BLANK_W-1:0] sensor_blank_ticks;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic [LIGHT_W-1:0] light_value;
        logic               light_error;
        logic [BAT_W-1:0]   battery_value;
    } t_item;

    typedef struct packed {
        logic             lamp_on;
        logic [BAT_W-1:0] lamp_level;
        logic             lamp_started;
        logic             sensor_power;
        logic             sensor_started;
        logic             light_sampled;
        logic             heartbeat;
    } t_result;

endpackage

>>> rtl/lgml_ifs.sv
// ----------------------------------------------------------------------------
// lgml request and response channels
// valid/ready channels carrying one input item or one result item
// ----------------------------------------------------------------------------
interface lgml_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] light_value;
    logic        light_error;
    logic [15:0] battery_value;

    modport source (output valid, kind, light_value, light_error, battery_value,
                    input ready);
    modport sink   (input valid, kind, light_value, light_error, battery_value,
                    output ready);
endinterface

interface lgml_rsp_if;
    logic        valid;
    logic        ready;
    logic        lamp_on;
    logic [15:0] lamp_level;
    logic        lamp_started;
    logic        sensor_power;
    logic        sensor_started;
    logic        light_sampled;
    logic        heartbeat;

    modport source (output valid, lamp_on, lamp_level, lamp_started, sensor_power,
                    sensor_started, light_sampled, heartbeat,
                    input ready);
    modport sink   (input valid, lamp_on, lamp_level, lamp_started, sensor_power,
                    sensor_started, light_sampled, heartbeat,
                    output ready);
endinterface

>>> rtl/lgml_cfg.sv
// ----------------------------------------------------------------------------
// lgml_cfg
// apb register file holding the controller settings
// ----------------------------------------------------------------------------
module lgml_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgml_pkg::APB_AW-1:0]  paddr,
    input  logic [lgml_pkg::APB_DW-1:0]  pwdata,
    output logic [lgml_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output lgml_pkg::t_cfg               o_cfg
);
    import lgml_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_AW-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_second      <= RST_TPS;
            r_cfg.lamp_on_seconds       <= RST_ON_SECS;
            r_cfg.light_low             <= RST_LOW;
            r_cfg.light_high            <= RST_HIGH;
            r_cfg.min_battery           <= RST_MIN_BAT;
            r_cfg.light_holdoff_seconds <= RST_HOLDOFF;
            r_cfg.sensor_blank_ticks    <= RST_BLANK;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TPS:     r_cfg.ticks_per_second      <= pwdata[TPS_W-1:0];
                REG_ON_SECS: r_cfg.lamp_on_seconds       <= pwdata[SECS_W-1:0];
                REG_LOW:     r_cfg.light_low             <= pwdata[LIGHT_W-1:0];
                REG_HIGH:    r_cfg.light_high            <= pwdata[LIGHT_W-1:0];
                REG_MIN_BAT: r_cfg.min_battery           <= pwdata[BAT_W-1:0];
                REG_HOLDOFF: r_cfg.light_holdoff_seconds <= pwdata[HOLD_W-1:0];
                REG_BLANK:   r_cfg.sensor_blank_ticks    <= pwdata[BLANK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TPS:     prdata = APB_DW'(r_cfg.ticks_per_second);
            REG_ON_SECS: prdata = APB_DW'(r_cfg.lamp_on_seconds);
            REG_LOW:     prdata = APB_DW'(r_cfg.light_low);
            REG_HIGH:    prdata = APB_DW'(r_cfg.light_high);
            REG_MIN_BAT: prdata = APB_DW'(r_cfg.min_battery);
            REG_HOLDOFF: prdata = APB_DW'(r_cfg.light_holdoff_seconds);
            REG_BLANK:   prdata = APB_DW'(r_cfg.sensor_blank_ticks);
            default:     prdata = '0;
        endcase
    end

endmodule

>>> rtl/lgml_core.sv
// ----------------------------------------------------------------------------
// lgml_core
// controller state and the combinational update for one request
// ----------------------------------------------------------------------------
`include "light_gated_motion_lamp_controller_macros.svh"

module lgml_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgml_pkg::t_cfg    i_cfg,
    input  logic              i_step,
    input  lgml_pkg::t_item   i_item,
    output logic              o_has_res,
    output lgml_pkg::t_result o_res
);
    import lgml_pkg::*;

    logic [TPS_W-1:0]   r_tick,  n_tick;
    logic [SECS_W-1:0]  r_lamp,  n_lamp;
    logic [HOLD_W-1:0]  r_hold,  n_hold;
    logic [BLANK_W-1:0] r_blank, n_blank;
    logic               r_sens,  n_sens;
    logic               r_pend,  n_pend;
    logic [BAT_W-1:0]   r_level, n_level;
    logic               r_beat,  n_beat;

    logic [TPS_W-1:0]   w_tick_inc;
    logic               w_started;
    logic               w_s_started;
    logic               w_sampled;

    assign w_tick_inc = r_tick + TPS_W'(1);

    always_comb begin
        n_tick      = r_tick;
        n_lamp      = r_lamp;
        n_hold      = r_hold;
        n_blank     = r_blank;
        n_sens      = r_sens;
        n_pend      = r_pend;
        n_level     = r_level;
        n_beat      = r_beat;
        w_started   = 1'b0;
        w_s_started = 1'b0;
        w_sampled   = 1'b0;
        if (i_item.kind == KIND_MOTION) begin
            n_pend = 1'b1;
        end else begin
            n_tick = w_tick_inc;
            // second boundary housekeeping
            if (w_tick_inc == i_cfg.ticks_per_second) begin
                n_tick = '0;
                n_beat = ~r_beat;
                if (r_lamp != '0) begin
                    n_lamp = r_lamp - SECS_W'(1);
                    if (n_lamp == '0) begin
                        n_hold = i_cfg.light_holdoff_seconds;
                    end
                end else if (r_hold != '0) begin
                    n_hold = r_hold - HOLD_W'(1);
                end else begin
                    w_sampled = 1'b1;
                    if (i_item.light_error || (i_item.light_value < i_cfg.light_low)) begin
                        if (!r_sens) begin
                            n_sens      = 1'b1;
                            w_s_started = 1'b1;
                            n_blank     = i_cfg.sensor_blank_ticks;
                        end
                    end else if (i_item.light_value > i_cfg.light_high) begin
                        if (r_sens) begin
                            n_sens = 1'b0;
                            n_pend = 1'b0;
                        end
                    end
                end
            end
            // blanking, then motion retrigger or lamp start
            if (n_blank != '0) begin
                n_blank = n_blank - BLANK_W'(1);
                n_pend  = 1'b0;
            end else if (n_sens && n_pend) begin
                n_pend = 1'b0;
                if (n_lamp == '0) begin
                    n_level = (i_item.battery_value < i_cfg.min_battery) ?
                              i_cfg.min_battery : i_item.battery_value;
                    w_started = 1'b1;
                end
                n_lamp = i_cfg.lamp_on_seconds;
            end
        end
    end

    assign o_has_res            = (i_item.kind == KIND_TICK);
    assign o_res.lamp_on        = (n_lamp != '0);
    assign o_res.lamp_level     = (n_lamp != '0) ? n_level : '0;
    assign o_res.lamp_started   = w_started;
    assign o_res.sensor_power   = n_sens;
    assign o_res.sensor_started = w_s_started;
    assign o_res.light_sampled  = w_sampled;
    assign o_res.heartbeat      = n_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_lamp  <= '0;
            r_hold  <= '0;
            r_blank <= '0;
            r_sens  <= 1'b0;
            r_pend  <= 1'b0;
            r_level <= '0;
            r_beat  <= 1'b0;
        end else if (i_step) begin
            r_tick  <= n_tick;
            r_lamp  <= n_lamp;
            r_hold  <= n_hold;
            r_blank <= n_blank;
            r_sens  <= n_sens;
            r_pend  <= n_pend;
            r_level <= n_level;
            r_beat  <= n_beat;
        end
    end

    // a tick during blanking discards pending motion
    `LGML_ASSERT_NEXT(a_blank_drops_motion, i_step && (i_item.kind == KIND_TICK) && (r_blank != '0), !r_pend)
    // a sensor power-up leaves the sensor on
    `LGML_ASSERT_NEXT(a_sensor_start_on, i_step && w_s_started, r_sens)
    // a lamp start loads the full on-time
    `LGML_ASSERT_NEXT(a_lamp_start_load, i_step && w_started, r_lamp == $past(i_cfg.lamp_on_seconds))

endmodule

>>> rtl/light_gated_motion_lamp_controller.sv
// ----------------------------------------------------------------------------
// light_gated_motion_lamp_controller
// lamp controller driven by tick and motion requests, gated by ambient light
// ----------------------------------------------------------------------------
// Takes one request per clock cycle with no bubbles while results are taken.
// A request goes into an input register; when it moves on, the controller
// state is updated from it by a single pass of logic, and at that same edge a
// tick request's result is loaded into an output register, which offers it.
// Motion requests update the state and give no result. A stalled result
// holds only the output register; the input register still fills, and the
// input side stops only when both are full. There is no clearing pass after
// reset. The user must write settings over the APB port only while the
// block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module light_gated_motion_lamp_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lgml_req_if.sink                     i_req,
    lgml_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgml_pkg::APB_AW-1:0]  paddr,
    input  logic [lgml_pkg::APB_DW-1:0]  pwdata,
    output logic [lgml_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import lgml_pkg::*;

    t_cfg    w_cfg;
    // input register stage
    logic    r_in_valid;
    t_item   r_in;
    // result register stage
    logic    r_out_valid;
    t_result r_out;
    // step control
    logic    w_advance;
    logic    w_has_res;
    t_result w_res;

    lgml_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the held request moves on when the result register is free or drains now
    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.kind          <= i_req.kind;
            r_in.light_value   <= i_req.light_value;
            r_in.light_error   <= i_req.light_error;
            r_in.battery_value <= i_req.battery_value;
        end
    end

    lgml_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_step    (w_advance),
        .i_item    (r_in),
        .o_has_res (w_has_res),
        .o_res     (w_res)
    );

    // result register: loaded on tick steps, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_has_res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_res) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.lamp_on        = r_out.lamp_on;
    assign o_rsp.lamp_level     = r_out.lamp_level;
    assign o_rsp.lamp_started   = r_out.lamp_started;
    assign o_rsp.sensor_power   = r_out.sensor_power;
    assign o_rsp.sensor_started = r_out.sensor_started;
    assign o_rsp.light_sampled  = r_out.light_sampled;
    assign o_rsp.heartbeat      = r_out.heartbeat;

endmodule
